@@ sv/weighted_priority_message_queues_unit_assert.svh @@
// Assertion macros for the weighted priority message queues unit.
// Used by the port checker; no other dependencies.
`ifndef WEIGHTED_PRIORITY_MESSAGE_QUEUES_UNIT_ASSERT_SVH
`define WEIGHTED_PRIORITY_MESSAGE_QUEUES_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define WPMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define WPMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wpmq_pkg.sv @@
// Shared types, constants and the credit scan function for the
// weighted priority message queues. No dependencies.
`default_nettype none

package wpmq_pkg;

    localparam int NUM_LEVELS      = 5;
    localparam int LVL_W           = $clog2(NUM_LEVELS);
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH       = 16;
    localparam int PRIO_W          = 3;
    localparam int WEIGHT_W        = 4;
    localparam int SCAN_PASSES     = 4;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 24;
    localparam int CFG_IDX_W       = 1;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_HIGH = WEIGHT_W'(2);
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_MID  = WEIGHT_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MID  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_PUSH  = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_EMPTY   = 2'd2,
        STS_NO_LAST = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // latch the transferred input item
        logic exec;   // carry out the latched command, load the result slot
    } t_dp_cmd;

    typedef struct packed {
        logic [PRIO_W-1:0]   served;
        logic [WEIGHT_W-1:0] ch;
        logic [WEIGHT_W-1:0] cm;
    } t_scan;

    // Credit scan over priorities four, three and two; at most four passes.
    function automatic t_scan f_scan(
        input logic [WEIGHT_W-1:0] ch,
        input logic [WEIGHT_W-1:0] cm,
        input logic [WEIGHT_W-1:0] wh,
        input logic [WEIGHT_W-1:0] wm,
        input logic                has4,
        input logic                has3,
        input logic                has2
    );
        t_scan r;
        logic  done;
        r.served = '0;
        r.ch     = ch;
        r.cm     = cm;
        done     = 1'b0;
        for (int p = 0; p < SCAN_PASSES; p++) begin
            if (!done) begin
                if (r.ch != '0 && has4) begin
                    r.served = PRIO_W'(4);
                    r.ch     = r.ch - WEIGHT_W'(1);
                    done     = 1'b1;
                end else if (r.cm != '0) begin
                    r.ch = wh;
                    if (has3) begin
                        r.served = PRIO_W'(3);
                        r.cm     = r.cm - WEIGHT_W'(1);
                        done     = 1'b1;
                    end
                end else begin
                    r.cm = wm;
                    if (has2) begin
                        r.served = PRIO_W'(2);
                        done     = 1'b1;
                    end
                end
                if (!has4 && !has3) begin
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/weighted_priority_message_queues_unit.sv @@
// Top level of the weighted priority message queues: controller plus datapath.
// Depends on wpmq_pkg, wpmq_ctrl and wpmq_dp.
//
//  channel   direction  tdata / tuser                                     transfer
//  s_axis    in         tuser: command[1:0]                               tvalid & tready
//                       tdata: msg_tag[15:0] priority_req[18:16] working[19]
//  m_axis    out        tdata: tag_valid[0] out_tag[16:1]                 tvalid & tready
//                              served_priority[19:17] status[21:20] any_queued[22]
//  cfg       in         i_cfg_addr 0 weight_high, 1 weight_mid            i_cfg_we
//
// Each item is transferred in, then its command runs in the execute state (scan,
// queue pointer update and at most one tag store access) and its result sits in
// the output register. The single-port tag store sets that execute state. No new
// item enters during execute; a stalled output holds execute until the slot frees.
// Reset is synchronous: queues empty, weights and credits 2, nothing served yet.
`default_nettype none

module weighted_priority_message_queues_unit import wpmq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // msg_tag, priority_req, working
    input  logic [1:0]           s_axis_tuser,  // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tag_valid, out_tag, served_priority, status, any_queued
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [WEIGHT_W-1:0]  i_cfg_data
);

    t_dp_cmd              dp_cmd;
    logic                 tag_valid;
    logic [TAG_WIDTH-1:0] out_tag;
    logic [PRIO_W-1:0]    served_priority;
    logic [1:0]           status;
    logic                 any_queued;

    wpmq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (dp_cmd)
    );

    // Unpack the input transfer straight into the datapath latch.
    wpmq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .i_command         (s_axis_tuser),
        .i_msg_tag         (s_axis_tdata[TAG_WIDTH-1:0]),
        .i_priority_req    (s_axis_tdata[TAG_WIDTH +: PRIO_W]),
        .i_working         (s_axis_tdata[TAG_WIDTH + PRIO_W]),
        .o_tag_valid       (tag_valid),
        .o_out_tag         (out_tag),
        .o_served_priority (served_priority),
        .o_status          (status),
        .o_any_queued      (any_queued)
    );

    // Pack the result, lowest field first; pad to whole bytes with zeros.
    assign m_axis_tdata = M_TDATA_W'({any_queued, status, served_priority, out_tag, tag_valid});

endmodule

`default_nettype wire

@@ sv/wpmq_ctrl.sv @@
// Controller for the weighted priority message queues: handshakes and
// sequencing of the datapath. Depends on wpmq_pkg.
`default_nettype none

module wpmq_ctrl import wpmq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready  = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

`default_nettype wire

@@ sv/wpmq_dp.sv @@
// Datapath for the weighted priority message queues: queue pointers, credit
// counters, weights, tag store and result slot. Depends on wpmq_pkg.
`default_nettype none

module wpmq_dp import wpmq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [WEIGHT_W-1:0]  i_cfg_data,
    input  logic [1:0]           i_command,
    input  logic [TAG_WIDTH-1:0] i_msg_tag,
    input  logic [PRIO_W-1:0]    i_priority_req,
    input  logic                 i_working,
    output logic                 o_tag_valid,
    output logic [TAG_WIDTH-1:0] o_out_tag,
    output logic [PRIO_W-1:0]    o_served_priority,
    output logic [1:0]           o_status,
    output logic                 o_any_queued
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int MEM_D  = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);

    // Latched input item
    t_cmd                 r_cmd;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [LVL_W-1:0]     r_lvl;
    logic                 r_working;

    // Queue and scheduler state
    logic [PTR_W-1:0]     r_head  [NUM_LEVELS];
    logic [CNT_W-1:0]     r_count [NUM_LEVELS];
    logic [PTR_W-1:0]     n_head  [NUM_LEVELS];
    logic [CNT_W-1:0]     n_count [NUM_LEVELS];
    logic [WEIGHT_W-1:0]  r_wh, r_wm, r_ch, r_cm, n_ch, n_cm;
    logic [PRIO_W-1:0]    r_last, n_last;

    // Tag store and result slot
    logic [TAG_WIDTH-1:0] mem [MEM_D];
    logic [TAG_WIDTH-1:0] r_rd_data;
    logic                 r_o_valid_tag;
    logic [PRIO_W-1:0]    r_o_served;
    t_status              r_o_status;
    logic                 r_o_any;

    logic [NUM_LEVELS-1:0] lvl_empty, lvl_full;
    t_scan                 scan;
    logic [PRIO_W-1:0]     served;
    t_status               status;
    logic [LVL_W-1:0]      op_idx;
    logic                  do_deq, do_enq, do_push, do_flush;
    logic [PTR_W-1:0]      sel_head;
    logic [CNT_W-1:0]      sel_count;
    logic [SUM_W-1:0]      head_inc, tail_sum;
    logic [PTR_W-1:0]      head_next, head_prev, tail_pos, offset;
    logic [ADDR_W-1:0]     addr;
    logic                  any_next;
    logic [LVL_W-1:0]      in_lvl;

    // Fold out-of-range priorities onto the end levels.
    always_comb begin
        if (i_priority_req == '0) begin
            in_lvl = '0;
        end else if (i_priority_req >= PRIO_W'(NUM_LEVELS)) begin
            in_lvl = LVL_W'(NUM_LEVELS - 1);
        end else begin
            in_lvl = LVL_W'(i_priority_req - PRIO_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= t_cmd'(i_command);
            r_tag     <= i_msg_tag;
            r_lvl     <= in_lvl;
            r_working <= i_working;
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_empty[i] = (r_count[i] == '0);
            lvl_full[i]  = (r_count[i] >= CNT_W'(QUEUE_DEPTH));
        end
    end

    assign scan = f_scan(r_ch, r_cm, r_wh, r_wm, !lvl_empty[3], !lvl_empty[2], !lvl_empty[1]);

    // Command decode
    always_comb begin
        n_ch     = r_ch;
        n_cm     = r_cm;
        n_last   = r_last;
        served   = '0;
        status   = STS_OK;
        op_idx   = r_lvl;
        do_deq   = 1'b0;
        do_enq   = 1'b0;
        do_push  = 1'b0;
        do_flush = 1'b0;
        case (r_cmd)
            CMD_ENQ: begin
                if (lvl_full[r_lvl]) begin
                    status = STS_FULL;
                end else begin
                    do_enq = 1'b1;
                end
            end
            CMD_DEQ: begin
                if (!lvl_empty[NUM_LEVELS-1]) begin
                    served = PRIO_W'(NUM_LEVELS);
                end else if (r_working) begin
                    n_ch = scan.ch;
                    n_cm = scan.cm;
                    if (scan.served != '0) begin
                        served = scan.served;
                    end else begin
                        // Empty scan still points push back at priority one.
                        n_last = PRIO_W'(1);
                        if (!lvl_empty[0]) begin
                            served = PRIO_W'(1);
                        end
                    end
                end
                if (served != '0) begin
                    do_deq = 1'b1;
                    n_last = served;
                    op_idx = LVL_W'(served - PRIO_W'(1));
                end else begin
                    status = STS_EMPTY;
                end
            end
            CMD_PUSH: begin
                if (r_last == '0) begin
                    status = STS_NO_LAST;
                end else begin
                    op_idx = LVL_W'(r_last - PRIO_W'(1));
                    if (lvl_full[op_idx]) begin
                        status = STS_FULL;
                    end else begin
                        do_push = 1'b1;
                    end
                end
            end
            CMD_FLUSH: begin
                do_flush = 1'b1;
            end
            default: ;
        endcase
    end

    // Ring pointer arithmetic for the selected queue
    assign sel_head  = r_head[op_idx];
    assign sel_count = r_count[op_idx];
    assign head_inc  = SUM_W'(sel_head) + SUM_W'(1);
    assign head_next = (head_inc >= SUM_W'(QUEUE_DEPTH)) ? '0 : PTR_W'(head_inc);
    assign head_prev = (sel_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : sel_head - PTR_W'(1);
    assign tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_count);
    assign tail_pos  = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                     ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

    always_comb begin
        if (do_enq) begin
            offset = tail_pos;
        end else if (do_push) begin
            offset = head_prev;
        end else begin
            offset = sel_head;
        end
    end

    assign addr = ADDR_W'(op_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(offset);

    always_comb begin
        any_next = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            n_head[i]  = r_head[i];
            n_count[i] = r_count[i];
            if (i_cmd.exec && op_idx == LVL_W'(i)) begin
                if (do_deq) begin
                    n_head[i]  = head_next;
                    n_count[i] = r_count[i] - CNT_W'(1);
                end else if (do_enq) begin
                    n_count[i] = r_count[i] + CNT_W'(1);
                end else if (do_push) begin
                    n_head[i]  = head_prev;
                    n_count[i] = r_count[i] + CNT_W'(1);
                end
            end
            if (i_cmd.exec && do_flush && i == NUM_LEVELS - 1) begin
                n_head[i]  = '0;
                n_count[i] = '0;
            end
            any_next = any_next | (n_count[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
            r_wh   <= RST_WEIGHT_HIGH;
            r_wm   <= RST_WEIGHT_MID;
            r_ch   <= RST_WEIGHT_HIGH;
            r_cm   <= RST_WEIGHT_MID;
            r_last <= '0;
        end else begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= n_head[i];
                r_count[i] <= n_count[i];
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WEIGHT_HIGH: r_wh <= i_cfg_data;
                    CFG_WEIGHT_MID:  r_wm <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_ch   <= n_ch;
                r_cm   <= n_cm;
                r_last <= n_last;
            end
        end
    end

    // Tag store: at most one access per executed command
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (do_enq || do_push)) begin
            mem[addr] <= r_tag;
        end
        if (i_cmd.exec && do_deq) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_valid_tag <= do_deq;
            r_o_served    <= served;
            r_o_status    <= status;
            r_o_any       <= any_next;
        end
    end

    assign o_tag_valid       = r_o_valid_tag;
    assign o_out_tag         = r_o_valid_tag ? r_rd_data : '0;
    assign o_served_priority = r_o_served;
    assign o_status          = r_o_status;
    assign o_any_queued      = r_o_any;

endmodule

`default_nettype wire

@@ sv/wpmq_checker.sv @@
// Port-level checker for the weighted priority message queues top level,
// bound to it below. Depends on the assertion macro header.
`default_nettype none

`include "weighted_priority_message_queues_unit_assert.svh"

module wpmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A served tag always reports ok status.
    `WPMQ_ASSERT_NOW(a_served_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[21:20] == 2'd0, "served tag with bad status")

    // Served priority is nonzero exactly when a tag came out.
    `WPMQ_ASSERT_NOW(a_served_prio, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[19:17] != 3'd0), "served priority disagrees with tag_valid")

    // No tag means a zero tag field.
    `WPMQ_ASSERT_NOW(a_tag_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[16:1] == 16'd0, "out_tag not zero without a tag")

    // The input side closes in the execute state after each transfer.
    `WPMQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input reopened during execute")

    // A stalled result holds.
    `WPMQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind weighted_priority_message_queues_unit wpmq_checker u_wpmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/weighted_priority_message_queues_unit_tb.sv @@
// Self-checking bench for the weighted priority message queues unit.
// Needs wpmq_pkg and the unit itself; tracks queue contents and credits on the side.
`default_nettype none

module weighted_priority_message_queues_unit_tb;
    import wpmq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no transfer at all
    localparam int PHASE_ITEMS     = 200;
    localparam int NUM_PHASES      = 8;
    localparam int PRESSURE_PHASE  = 4;

    typedef enum int { MIX_BALANCED, MIX_FILL, MIX_DRAIN } t_mix;

    // Result word as it leaves the unit, lowest bit last in this list.
    typedef struct packed {
        logic                 any_queued;
        logic [1:0]           status;
        logic [PRIO_W-1:0]    served;
        logic [TAG_WIDTH-1:0] out_tag;
        logic                 tag_valid;
    } t_outcome;

    // Mirror of the five tag queues and the credit counters. Every command
    // produces exactly one outcome, which is queued here until it shows up.
    class queue_tracker;
        logic [TAG_WIDTH-1:0] store [NUM_LEVELS][QUEUE_DEPTH_DEF];
        int unsigned          head [NUM_LEVELS];
        int unsigned          count [NUM_LEVELS];
        int unsigned          credit_high, credit_mid;
        int unsigned          weight_high, weight_mid;
        int unsigned          last_served;
        t_outcome             expected_outcomes [$];
        int                   fail_count;

        function new();
            foreach (head[q]) begin
                head[q]  = 0;
                count[q] = 0;
            end
            weight_high = RST_WEIGHT_HIGH;
            weight_mid  = RST_WEIGHT_MID;
            credit_high = RST_WEIGHT_HIGH;
            credit_mid  = RST_WEIGHT_MID;
            last_served = 0;
            fail_count  = 0;
        endfunction

        function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] value);
            if (idx == CFG_WEIGHT_HIGH) weight_high = value;
            else                        weight_mid  = value;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // Work out the outcome of one accepted command and queue it.
        function void note_command(t_cmd cmd, logic [TAG_WIDTH-1:0] tag,
                                   logic [PRIO_W-1:0] prio_raw, logic working);
            t_outcome    o;
            int unsigned lvl, q, served, pos;
            logic        stop;
            o      = '0;
            served = 0;
            stop   = 1'b0;
            // clamp out-of-range priorities onto the nearest level
            lvl = (prio_raw == 0) ? 1 : (prio_raw > 5) ? 5 : prio_raw;
            case (cmd)
                CMD_ENQ: begin
                    q = lvl - 1;
                    if (count[q] >= QUEUE_DEPTH_DEF) begin
                        o.status = STS_FULL;
                    end else begin
                        pos = (head[q] + count[q]) % QUEUE_DEPTH_DEF;
                        store[q][pos] = tag;
                        count[q]++;
                    end
                end
                CMD_DEQ: begin
                    if (count[4] != 0) begin
                        served = 5;
                    end else if (working) begin
                        // credit scan over levels four, three and two
                        for (int p = 0; p < SCAN_PASSES; p++) begin
                            if (!stop) begin
                                if (credit_high > 0 && count[3] != 0) begin
                                    served = 4;
                                    credit_high--;
                                    stop = 1'b1;
                                end else if (credit_mid > 0) begin
                                    credit_high = weight_high;
                                    if (count[2] != 0) begin
                                        served = 3;
                                        credit_mid--;
                                        stop = 1'b1;
                                    end
                                end else begin
                                    credit_mid = weight_mid;
                                    if (count[1] != 0) begin
                                        served = 2;
                                        stop = 1'b1;
                                    end
                                end
                                if (count[3] == 0 && count[2] == 0) stop = 1'b1;
                            end
                        end
                        // an empty scan still points push back at level one
                        if (served == 0) begin
                            last_served = 1;
                            if (count[0] != 0) served = 1;
                        end
                    end
                    if (served != 0) begin
                        q = served - 1;
                        o.out_tag   = store[q][head[q]];
                        o.tag_valid = 1'b1;
                        o.served    = PRIO_W'(served);
                        head[q]     = (head[q] + 1) % QUEUE_DEPTH_DEF;
                        count[q]--;
                        last_served = served;
                    end else begin
                        o.status = STS_EMPTY;
                    end
                end
                CMD_PUSH: begin
                    if (last_served == 0) begin
                        o.status = STS_NO_LAST;
                    end else begin
                        q = last_served - 1;
                        if (count[q] >= QUEUE_DEPTH_DEF) begin
                            o.status = STS_FULL;
                        end else begin
                            head[q] = (head[q] + QUEUE_DEPTH_DEF - 1) % QUEUE_DEPTH_DEF;
                            store[q][head[q]] = tag;
                            count[q]++;
                        end
                    end
                end
                default: begin
                    count[4] = 0;
                    head[4]  = 0;
                end
            endcase
            foreach (count[i])
                if (count[i] != 0) o.any_queued = 1'b1;
            expected_outcomes.push_back(o);
        endfunction

        // Compare one transferred result with the oldest outstanding outcome.
        function void check_outcome(t_outcome got);
            t_outcome want;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result with nothing outstanding, expected none, actual %h",
                         $realtime, got);
                fail_count++;
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.tag_valid !== want.tag_valid) begin
                $display("%0t: tag_valid expected %0d actual %0d",
                         $realtime, want.tag_valid, got.tag_valid);
                fail_count++;
            end
            if (got.out_tag !== want.out_tag) begin
                $display("%0t: out_tag expected %h actual %h",
                         $realtime, want.out_tag, got.out_tag);
                fail_count++;
            end
            if (got.served !== want.served) begin
                $display("%0t: served_priority expected %0d actual %0d",
                         $realtime, want.served, got.served);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $realtime, want.status, got.status);
                fail_count++;
            end
            if (got.any_queued !== want.any_queued) begin
                $display("%0t: any_queued expected %0d actual %0d",
                         $realtime, want.any_queued, got.any_queued);
                fail_count++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // msg_tag[15:0] priority_req[18:16] working[19]
    logic [1:0]           s_axis_tuser = CMD_ENQ;  // command[1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tag_valid[0] out_tag[16:1] served_priority[19:17] status[21:20] any_queued[22]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = CFG_WEIGHT_HIGH;
    logic [WEIGHT_W-1:0]  i_cfg_data = '0;

    queue_tracker tracker = new();

    // Test control shared between the sender and the receiver.
    logic hold_off_req = 1'b0;
    logic rx_quiet     = 1'b0;
    logic tx_quiet     = 1'b0;
    int   idle_cycles  = 0;

    weighted_priority_message_queues_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; never zero.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Check every result transfer as it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_outcome(t_outcome'(m_axis_tdata[$bits(t_outcome)-1:0]));
    end

    // Watchdog: give up when neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: ready bursts broken by random stalls, plus one long hold-off
    // on request so the unit backs up and stalls its input.
    initial begin : receiver
        int burst;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                burst = $urandom_range(1, 12);
                repeat (burst) @(posedge i_clk);
                if (!rx_quiet && !hold_off_req) begin
                    m_axis_tready <= 1'b0;
                    repeat (pick_gap()) @(posedge i_clk);
                end
            end
        end
    end

    // Offer one command after an optional gap; return once it is transferred.
    task automatic send_command(t_cmd cmd, logic [TAG_WIDTH-1:0] tag,
                                logic [PRIO_W-1:0] prio, logic working, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_TDATA_W - TAG_WIDTH - PRIO_W - 1){1'b0}}, working, prio, tag};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_command(cmd, tag, prio, working);
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Program both weights; only called with the unit idle.
    task automatic write_weights(logic [WEIGHT_W-1:0] high, logic [WEIGHT_W-1:0] mid);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_WEIGHT_HIGH;
        i_cfg_data <= high;
        @(posedge i_clk);
        tracker.set_weight(CFG_WEIGHT_HIGH, high);
        i_cfg_addr <= CFG_WEIGHT_MID;
        i_cfg_data <= mid;
        @(posedge i_clk);
        tracker.set_weight(CFG_WEIGHT_MID, mid);
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    // Short directed run: push back before any service, empty dequeues in
    // both modes, clamped priorities, tag extremes, flush and the credit scan.
    task automatic run_directed();
        send_command(CMD_PUSH,  16'h1234, 3'd3, 1'b1, 0);  // nothing served yet
        send_command(CMD_DEQ,   16'h0000, 3'd1, 1'b0, 0);  // idle mode, empty
        send_command(CMD_PUSH,  16'h4321, 3'd2, 1'b0, 1);  // still nothing served
        send_command(CMD_DEQ,   16'h0000, 3'd1, 1'b1, 0);  // empty scan lands on level one
        send_command(CMD_PUSH,  16'hFFFF, 3'd4, 1'b1, 0);  // goes to level one
        send_command(CMD_ENQ,   16'h0000, 3'd0, 1'b0, 0);  // priority 0 taken as 1
        send_command(CMD_ENQ,   16'hFFFF, 3'd7, 1'b1, 2);  // priority 7 taken as 5
        send_command(CMD_ENQ,   16'hA5A5, 3'd6, 1'b0, 0);  // priority 6 taken as 5
        send_command(CMD_ENQ,   16'h0004, 3'd4, 1'b1, 0);
        send_command(CMD_ENQ,   16'h0003, 3'd3, 1'b1, 0);
        send_command(CMD_ENQ,   16'h0002, 3'd2, 1'b1, 0);
        send_command(CMD_ENQ,   16'h1004, 3'd4, 1'b1, 0);
        send_command(CMD_ENQ,   16'h1003, 3'd3, 1'b1, 0);
        send_command(CMD_DEQ,   16'h0000, 3'd1, 1'b0, 0);  // level five first
        send_command(CMD_FLUSH, 16'h0000, 3'd5, 1'b1, 0);
        send_command(CMD_DEQ,   16'h0000, 3'd1, 1'b0, 0);  // idle mode, five now empty
        repeat (5) send_command(CMD_DEQ, 16'h0000, 3'd1, 1'b1, 0);
        send_command(CMD_PUSH,  16'h5A5A, 3'd1, 1'b1, 0);  // back to last served level
        repeat (2) send_command(CMD_DEQ, 16'h0000, 3'd1, 1'b1, 1);
    endtask

    // Random commands whose mix leans toward filling, draining or neither.
    task automatic run_phase(int phase, t_mix mix);
        t_cmd              cmd;
        logic [PRIO_W-1:0] prio;
        int                r, enq_pct, deq_pct, push_pct, gap;
        case (mix)
            MIX_FILL:  begin enq_pct = 70; deq_pct = 20; push_pct = 7; end
            MIX_DRAIN: begin enq_pct = 30; deq_pct = 60; push_pct = 8; end
            default:   begin enq_pct = 45; deq_pct = 43; push_pct = 9; end
        endcase
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < enq_pct)                           cmd = CMD_ENQ;
            else if (r < enq_pct + deq_pct)            cmd = CMD_DEQ;
            else if (r < enq_pct + deq_pct + push_pct) cmd = CMD_PUSH;
            else                                       cmd = CMD_FLUSH;
            // keep level five light so the scan below it gets exercised
            r = $urandom_range(0, 99);
            if (r < 6)       prio = (r < 2) ? 3'd0 : (r < 4) ? 3'd6 : 3'd7;
            else if (r < 16) prio = 3'd5;
            else             prio = PRIO_W'($urandom_range(1, 4));
            // long receiver hold-off while the sender keeps pushing
            if (phase == PRESSURE_PHASE && n == 50) hold_off_req = 1'b1;
            if (tx_quiet || (phase == PRESSURE_PHASE && n >= 50 && n < 90))
                gap = 0;
            else
                gap = ($urandom_range(0, 99) < 45) ? 0 : pick_gap();
            send_command(cmd, TAG_WIDTH'($urandom_range(0, 65535)), prio,
                         $urandom_range(0, 99) < 90, gap);
        end
    endtask

    initial begin : stimulus
        logic [WEIGHT_W-1:0] high, mid;
        t_mix                mix;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // pause until everything is back, then retune the weights
            drain();
            case (ph)
                0:       begin high = 4'd2;  mid = 4'd2;  mix = MIX_BALANCED; end
                1:       begin high = 4'd0;  mid = 4'd0;  mix = MIX_BALANCED; end
                2:       begin high = 4'd15; mid = 4'd15; mix = MIX_FILL;     end
                3:       begin high = 4'd15; mid = 4'd0;  mix = MIX_DRAIN;    end
                4:       begin high = 4'd0;  mid = 4'd15; mix = MIX_BALANCED; end
                5:       begin high = 4'd1;  mid = 4'd1;  mix = MIX_FILL;     end
                6:       begin
                    high = WEIGHT_W'($urandom);
                    mid  = WEIGHT_W'($urandom);
                    mix  = MIX_BALANCED;
                end
                default: begin
                    high = WEIGHT_W'($urandom);
                    mid  = WEIGHT_W'($urandom);
                    mix  = MIX_DRAIN;
                end
            endcase
            write_weights(high, mid);
            tx_quiet = (ph == 1 || ph == 5);
            rx_quiet = (ph == 2 || ph == 6);
            run_phase(ph, mix);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (tracker.fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
